>>> rtl/bsfr_pkg.sv
// Package for the byte-stuffed frame receiver.
// Holds the shared types, codes and constants; no dependencies.
`default_nettype none

package bsfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_FLAG = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ADDRESS = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CTRL_I0 = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CTRL_I1 = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CTRL_DISC = 3'd5;

  localparam logic [ByteW-1:0] RST_FLAG = 8'h7E;
  localparam logic [ByteW-1:0] RST_ESCAPE = 8'h7D;
  localparam logic [ByteW-1:0] RST_ADDRESS = 8'h03;
  localparam logic [ByteW-1:0] RST_CTRL_I0 = 8'h00;
  localparam logic [ByteW-1:0] RST_CTRL_I1 = 8'h40;
  localparam logic [ByteW-1:0] RST_CTRL_DISC = 8'h0B;

  localparam logic [ByteW-1:0] ESC_FLAG_CODE = 8'h5E;
  localparam logic [ByteW-1:0] ESC_ESC_CODE = 8'h5D;

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_FLAG,
    ST_ADDR,
    ST_CTRL,
    ST_DISC_OK,
    ST_PAYLOAD
  } rx_state_e;

  typedef enum logic [1:0] {
    KIND_I0 = 2'd0,
    KIND_I1 = 2'd1,
    KIND_DISC = 2'd2
  } frame_kind_e;

  typedef enum logic [1:0] {
    STATUS_ACCEPTED = 2'd0,
    STATUS_OUT_OF_SEQ = 2'd1,
    STATUS_CHECK_ERR = 2'd2,
    STATUS_DISCONNECT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REPLY_NONE = 2'd0,
    REPLY_RR = 2'd1,
    REPLY_REJ = 2'd2
  } reply_e;

  typedef struct packed {
    logic [ByteW-1:0] flag_byte;
    logic [ByteW-1:0] escape_byte;
  } stuff_cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic is_flag;
    logic is_esc;
    logic is_addr;
    logic is_i0;
    logic is_i1;
    logic is_disc;
    logic chk_i0;
    logic chk_i1;
    logic chk_disc;
    logic is_esc_flag;
    logic is_esc_esc;
  } byte_cls_t;

  typedef struct packed {
    logic frame_end;
    logic [ByteW-1:0] payload_byte;
    status_e status;
    logic frame_seq;
    reply_e reply_kind;
    logic reply_seq;
  } rx_result_t;

endpackage

`default_nettype wire

>>> rtl/bsfr_fifo.sv
// Small flop-based queue used between the receiver stages and at the output.
// Generic in width and depth; no package dependencies.
`default_nettype none

module bsfr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bsfr_front.sv
// Front end of the receiver: configuration registers and byte classifier.
// Depends on bsfr_pkg.
`default_nettype none

module bsfr_front
  import bsfr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ByteW-1:0]   cfg_data_i,
  input  wire logic [ByteW-1:0]   rx_byte_i,
  output byte_cls_t               cls_o,
  output stuff_cfg_t              stuff_cfg_o
);

  logic [ByteW-1:0] flag_q, esc_q, addr_q, ctrl_i0_q, ctrl_i1_q, ctrl_disc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= RST_FLAG;
      esc_q <= RST_ESCAPE;
      addr_q <= RST_ADDRESS;
      ctrl_i0_q <= RST_CTRL_I0;
      ctrl_i1_q <= RST_CTRL_I1;
      ctrl_disc_q <= RST_CTRL_DISC;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FLAG: flag_q <= cfg_data_i;
        CFG_ESCAPE: esc_q <= cfg_data_i;
        CFG_ADDRESS: addr_q <= cfg_data_i;
        CFG_CTRL_I0: ctrl_i0_q <= cfg_data_i;
        CFG_CTRL_I1: ctrl_i1_q <= cfg_data_i;
        CFG_CTRL_DISC: ctrl_disc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cls_o.data = rx_byte_i;
    cls_o.is_flag = (rx_byte_i == flag_q);
    cls_o.is_esc = (rx_byte_i == esc_q);
    cls_o.is_addr = (rx_byte_i == addr_q);
    cls_o.is_i0 = (rx_byte_i == ctrl_i0_q);
    cls_o.is_i1 = (rx_byte_i == ctrl_i1_q);
    cls_o.is_disc = (rx_byte_i == ctrl_disc_q);
    cls_o.chk_i0 = (rx_byte_i == (addr_q ^ ctrl_i0_q));
    cls_o.chk_i1 = (rx_byte_i == (addr_q ^ ctrl_i1_q));
    cls_o.chk_disc = (rx_byte_i == (addr_q ^ ctrl_disc_q));
    cls_o.is_esc_flag = (rx_byte_i == ESC_FLAG_CODE);
    cls_o.is_esc_esc = (rx_byte_i == ESC_ESC_CODE);
  end

  assign stuff_cfg_o.flag_byte = flag_q;
  assign stuff_cfg_o.escape_byte = esc_q;

endmodule

`default_nettype wire

>>> rtl/bsfr_back.sv
// Back end of the receiver: frame state machine, destuffing and check.
// Depends on bsfr_pkg; consumes classified bytes and produces results.
`default_nettype none

module bsfr_back
  import bsfr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire byte_cls_t  cls_i,
  input  wire stuff_cfg_t stuff_cfg_i,
  output logic            res_valid_o,
  output rx_result_t      res_o
);

  rx_state_e state_q, state_d;
  frame_kind_e kind_q, kind_d;
  logic esc_pend_q, esc_pend_d;
  logic [ByteW-1:0] held_q, held_d;
  logic held_vld_q, held_vld_d;
  logic [ByteW-1:0] chk_q, chk_d;
  logic exp_q, exp_d;
  logic dlv;
  logic [ByteW-1:0] dlv_byte;
  logic hdr_chk;

  always_comb begin
    case (kind_q)
      KIND_I0: hdr_chk = cls_i.chk_i0;
      KIND_I1: hdr_chk = cls_i.chk_i1;
      default: hdr_chk = cls_i.chk_disc;
    endcase
  end

  always_comb begin
    state_d = state_q;
    kind_d = kind_q;
    esc_pend_d = esc_pend_q;
    held_d = held_q;
    held_vld_d = held_vld_q;
    chk_d = chk_q;
    exp_d = exp_q;
    dlv = 1'b0;
    dlv_byte = cls_i.data;
    res_valid_o = 1'b0;
    res_o = '0;
    if (step_i) begin
      case (state_q)
        ST_FLAG: begin
          if (cls_i.is_addr) begin
            state_d = ST_ADDR;
          end else if (!cls_i.is_flag) begin
            state_d = ST_WAIT;
          end
        end
        ST_ADDR: begin
          if (cls_i.is_i0) begin
            kind_d = KIND_I0;
            state_d = ST_CTRL;
          end else if (cls_i.is_i1) begin
            kind_d = KIND_I1;
            state_d = ST_CTRL;
          end else if (cls_i.is_disc) begin
            kind_d = KIND_DISC;
            state_d = ST_CTRL;
          end else if (cls_i.is_flag) begin
            state_d = ST_FLAG;
          end else begin
            state_d = ST_WAIT;
          end
        end
        ST_CTRL: begin
          if (hdr_chk) begin
            if (kind_q == KIND_DISC) begin
              state_d = ST_DISC_OK;
            end else begin
              state_d = ST_PAYLOAD;
              esc_pend_d = 1'b0;
              held_d = '0;
              held_vld_d = 1'b0;
              chk_d = '0;
            end
          end else if (cls_i.is_flag) begin
            state_d = ST_FLAG;
          end else begin
            state_d = ST_WAIT;
          end
        end
        ST_DISC_OK: begin
          state_d = ST_WAIT;
          if (cls_i.is_flag) begin
            res_valid_o = 1'b1;
            res_o.frame_end = 1'b1;
            res_o.status = STATUS_DISCONNECT;
          end
        end
        ST_PAYLOAD: begin
          if (cls_i.is_flag) begin
            state_d = ST_WAIT;
            res_valid_o = 1'b1;
            res_o.frame_end = 1'b1;
            res_o.frame_seq = kind_q[0];
            if (!held_vld_q || (held_q != chk_q)) begin
              res_o.status = STATUS_CHECK_ERR;
              res_o.reply_kind = REPLY_REJ;
              res_o.reply_seq = exp_q;
            end else if (kind_q[0] != exp_q) begin
              res_o.status = STATUS_OUT_OF_SEQ;
              res_o.reply_kind = REPLY_REJ;
              res_o.reply_seq = exp_q;
            end else begin
              exp_d = ~exp_q;
              res_o.status = STATUS_ACCEPTED;
              res_o.reply_kind = REPLY_RR;
              res_o.reply_seq = ~exp_q;
            end
            esc_pend_d = 1'b0;
            held_d = '0;
            held_vld_d = 1'b0;
            chk_d = '0;
          end else if (esc_pend_q && cls_i.is_esc_flag) begin
            esc_pend_d = 1'b0;
            dlv = 1'b1;
            dlv_byte = stuff_cfg_i.flag_byte;
          end else if (esc_pend_q && cls_i.is_esc_esc) begin
            esc_pend_d = 1'b0;
            dlv = 1'b1;
            dlv_byte = stuff_cfg_i.escape_byte;
          end else if (cls_i.is_esc) begin
            esc_pend_d = 1'b1;
          end else begin
            esc_pend_d = 1'b0;
            dlv = 1'b1;
          end
        end
        default: begin
          state_d = cls_i.is_flag ? ST_FLAG : ST_WAIT;
        end
      endcase
      if (dlv) begin
        if (held_vld_q) begin
          res_valid_o = 1'b1;
          res_o.payload_byte = held_q;
          chk_d = chk_q ^ held_q;
        end
        held_d = dlv_byte;
        held_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WAIT;
      kind_q <= KIND_I0;
      esc_pend_q <= 1'b0;
      held_q <= '0;
      held_vld_q <= 1'b0;
      chk_q <= '0;
      exp_q <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q <= kind_d;
      esc_pend_q <= esc_pend_d;
      held_q <= held_d;
      held_vld_q <= held_vld_d;
      chk_q <= chk_d;
      exp_q <= exp_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/byte_stuffed_frame_receiver.sv
// Byte-stuffed frame receiver, top level.
// Depends on bsfr_pkg, bsfr_front, bsfr_fifo and bsfr_back.
//
// Raw line bytes enter on rx_byte_i; a beat is taken at a clock edge with push
// high and full low. Results leave as a queue: while empty is low the oldest
// result sits on the result ports, and a beat is taken with pop high.
// A result is either a destuffed payload byte (frame_end_o low) or a
// frame-end status with the reply to send (frame_end_o high). Payload bytes
// come out one destuffed byte late, since the last one of a frame is its check.
// The front classifies each byte against the configuration registers and
// queues it; the back runs the frame state machine and queues results.
// One byte is taken every cycle while full is low; a beat waits in the byte
// queue and any result in the result queue. When the result queue fills because
// pop stays low, the back stops, the byte queue fills, and full rises.
// Reset empties both queues, returns the configuration registers to their
// defaults and sets the frame state machine to wait for an opening flag.
// Configuration writes take effect at once with no handshake.
`default_nettype none

module byte_stuffed_frame_receiver
  import bsfr_pkg::*;
#(
  parameter int unsigned CMD_DEPTH = 2,
  parameter int unsigned RES_DEPTH = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ByteW-1:0]   cfg_data_i,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [ByteW-1:0]   rx_byte_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    frame_end_o,
  output logic [ByteW-1:0]        payload_byte_o,
  output logic [1:0]              status_o,
  output logic                    frame_seq_o,
  output logic [1:0]              reply_kind_o,
  output logic                    reply_seq_o
);

  byte_cls_t cls_in, cls_head;
  stuff_cfg_t stuff_cfg;
  logic cmd_empty, cmd_full;
  logic res_full, res_valid, step;
  rx_result_t res_in, res_head;

  bsfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .rx_byte_i   (rx_byte_i),
    .cls_o       (cls_in),
    .stuff_cfg_o (stuff_cfg)
  );

  bsfr_fifo #(
    .WIDTH ($bits(byte_cls_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls_in),
    .full_o  (cmd_full),
    .pop_i   (step),
    .data_o  (cls_head),
    .empty_o (cmd_empty)
  );

  assign full = cmd_full;
  assign step = !cmd_empty && !res_full;

  bsfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .cls_i       (cls_head),
    .stuff_cfg_i (stuff_cfg),
    .res_valid_o (res_valid),
    .res_o       (res_in)
  );

  bsfr_fifo #(
    .WIDTH ($bits(rx_result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_head),
    .empty_o (empty)
  );

  assign frame_end_o = res_head.frame_end;
  assign payload_byte_o = res_head.payload_byte;
  assign status_o = res_head.status;
  assign frame_seq_o = res_head.frame_seq;
  assign reply_kind_o = res_head.reply_kind;
  assign reply_seq_o = res_head.reply_seq;

endmodule

`default_nettype wire
